// ===== design/size_class_free_list_allocator_core_assert.svh =====
// Assertion macros for the size-class allocator.
// Included by the top level; needs nothing else.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

// Property checked on the rising clock edge, off while reset is low.
`define SCFLA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never hold, off while reset is low.
`define SCFLA_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// ===== design/scfla_pkg.sv =====
// Shared constants, codes, command/status types and count helpers
// for the size-class allocator. No dependencies.
package scfla_pkg;

    localparam int SLAB_BLOCKS     = 64;
    localparam int MAX_SLABS       = 16;
    localparam int CLASS_COUNT     = 4;

    localparam int SMALLEST_BYTES  = 64;
    localparam int COUNT_W         = 11;
    localparam int HANDLE_OUT_W    = 10;
    localparam int STEP_W          = 9;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_STATS = 2'd2,
        MODE_CLEAR = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_NO_SLABS  = 2'd2,
        ST_IGNORED   = 2'd3
    } t_status;

    typedef struct packed {
        logic load;
        logic finish;
        logic rd_head;
        logic fill_init;
        logic fill_wr;
        logic pop;
    } t_cmd;

    typedef struct packed {
        logic alloc_hit;
        logic alloc_refill;
        logic fill_last;
        logic rsp_open;
    } t_stat;

    function automatic logic [COUNT_W-1:0] count_up(logic [COUNT_W-1:0] v,
                                                    logic [STEP_W-1:0] n);
        logic [COUNT_W:0] s;
        s = {1'b0, v} + (COUNT_W+1)'(n);
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] count_down(logic [COUNT_W-1:0] v);
        return (v == '0) ? '0 : v - COUNT_W'(1);
    endfunction

endpackage

// ===== design/scfla_if.sv =====
// Valid/ready channel interfaces for request and response items.
// Standalone; no package dependency.
interface scfla_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [31:0] request_size;
    logic [9:0]  block_handle;
    logic        handle_present;
    logic [2:0]  class_select;

    modport source (output valid, mode, request_size, block_handle, handle_present,
                    class_select, input ready);
    modport sink   (input valid, mode, request_size, block_handle, handle_present,
                    class_select, output ready);
endinterface

interface scfla_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [9:0]  granted_handle;
    logic [1:0]  size_class;
    logic [10:0] allocated_count;
    logic [10:0] spare_count;

    modport source (output valid, status, granted_handle, size_class, allocated_count,
                    spare_count, input ready);
    modport sink   (input valid, status, granted_handle, size_class, allocated_count,
                    spare_count, output ready);
endinterface

// ===== design/scfla_ctrl.sv =====
// Controller FSM: sequences accept, execute, slab fill, link read and pop.
// Depends on scfla_pkg for command and status types.
module scfla_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_req_valid,
    input  scfla_pkg::t_stat   i_stat,
    output scfla_pkg::t_cmd    o_cmd,
    output logic               o_req_ready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_RD,
        S_POP
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_req_valid;
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                priority if (i_stat.alloc_hit) begin
                    o_cmd.rd_head = 1'b1;
                    n_state       = S_POP;
                end else if (i_stat.alloc_refill) begin
                    o_cmd.fill_init = 1'b1;
                    n_state         = S_FILL;
                end else begin
                    if (i_stat.rsp_open) begin
                        o_cmd.finish = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_stat.fill_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = S_POP;
            end
            S_POP: begin
                if (i_stat.rsp_open) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_req_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== design/scfla_dp.sv =====
// Datapath: request registers, per-class heads and counts, link memory,
// slab fill counter and result register. Depends on scfla_pkg.
module scfla_dp #(
    parameter int SLAB_BLOCKS     = scfla_pkg::SLAB_BLOCKS,
    parameter int MAX_SLABS       = scfla_pkg::MAX_SLABS,
    parameter int CLASS_COUNT     = scfla_pkg::CLASS_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  scfla_pkg::t_cmd               i_cmd,
    output scfla_pkg::t_stat              o_stat,
    input  logic [1:0]                    i_mode,
    input  logic [31:0]                   i_request_size,
    input  logic [9:0]                    i_block_handle,
    input  logic                          i_handle_present,
    input  logic [2:0]                    i_class_select,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [1:0]                    o_status,
    output logic [9:0]                    o_granted_handle,
    output logic [1:0]                    o_size_class,
    output logic [10:0]                   o_allocated_count,
    output logic [10:0]                   o_spare_count
);

    localparam int HANDLES = MAX_SLABS * SLAB_BLOCKS;
    localparam int HW      = (HANDLES > 1) ? $clog2(HANDLES) : 1;
    localparam int CW      = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int SW      = $clog2(MAX_SLABS + 1);
    localparam int FW      = (SLAB_BLOCKS > 1) ? $clog2(SLAB_BLOCKS) : 1;
    localparam int AW      = CW + HW;
    localparam int DEPTH   = CLASS_COUNT * (2 ** HW);
    localparam int CNT_W   = scfla_pkg::COUNT_W;

    // latched request
    scfla_pkg::t_mode  r_mode;
    logic              r_large;
    logic [CW-1:0]     r_cls;
    logic [9:0]        r_handle;
    logic              r_present;
    logic [2:0]        r_sel;

    // per-class state
    logic [HW-1:0]     r_head     [CLASS_COUNT];
    logic              r_head_vld [CLASS_COUNT];
    logic [SW-1:0]     r_slabs    [CLASS_COUNT];
    logic [CNT_W-1:0]  r_live     [CLASS_COUNT];
    logic [CNT_W-1:0]  r_idle     [CLASS_COUNT];

    // link memory: {valid, next handle}
    logic [HW:0]       r_mem [DEPTH];
    logic [HW:0]       r_rdata;

    logic [HW-1:0]     r_fill_addr;
    logic [FW-1:0]     r_fill_cnt;

    logic                       r_out_valid;
    scfla_pkg::t_status         r_out_status;
    logic [9:0]                 r_out_handle;
    logic [1:0]                 r_out_class;
    logic [CNT_W-1:0]           r_out_alloc;
    logic [CNT_W-1:0]           r_out_spare;

    logic [31:0]       w_size_eff;
    logic              w_large;
    logic [CW-1:0]     w_cls;

    logic [HW-1:0]     w_cur_head;
    logic              w_cur_vld;
    logic [SW-1:0]     w_cur_slabs;
    logic [CNT_W-1:0]  w_cur_live;
    logic [CNT_W-1:0]  w_cur_idle;
    logic [CNT_W-1:0]  w_live_up;
    logic [CNT_W-1:0]  w_live_dn;
    logic [CNT_W-1:0]  w_idle_up;
    logic [CNT_W-1:0]  w_idle_dn;
    logic [CNT_W-1:0]  w_idle_slab;
    logic [HW-1:0]     w_first;
    logic [HW-1:0]     w_free_idx;
    logic              w_free_ok;
    logic              w_free_push;
    logic              w_alloc_go;
    logic              w_sel_ok;
    logic [CW-1:0]     w_sel_idx;
    logic              w_clear;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [HW:0]       w_wdata;

    scfla_pkg::t_status  w_res_status;
    logic [CW-1:0]       w_res_cls;
    logic [CNT_W-1:0]    w_res_alloc;
    logic [CNT_W-1:0]    w_res_free;

    // size class decode at accept
    assign w_size_eff = (i_request_size == 32'd0) ? 32'd1 : i_request_size;

    always_comb begin
        w_large = 1'b1;
        w_cls   = '0;
        for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
            if (w_size_eff <= (32'(scfla_pkg::SMALLEST_BYTES) << c)) begin
                w_large = 1'b0;
                w_cls   = CW'(c);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= scfla_pkg::t_mode'(i_mode);
            r_large   <= w_large;
            r_cls     <= w_cls;
            r_handle  <= i_block_handle;
            r_present <= i_handle_present;
            r_sel     <= i_class_select;
        end
    end

    assign w_cur_head  = r_head[r_cls];
    assign w_cur_vld   = r_head_vld[r_cls];
    assign w_cur_slabs = r_slabs[r_cls];
    assign w_cur_live  = r_live[r_cls];
    assign w_cur_idle  = r_idle[r_cls];

    assign w_live_up   = scfla_pkg::count_up(w_cur_live, scfla_pkg::STEP_W'(1));
    assign w_idle_up   = scfla_pkg::count_up(w_cur_idle, scfla_pkg::STEP_W'(1));
    assign w_idle_slab = scfla_pkg::count_up(w_cur_idle,
                                             scfla_pkg::STEP_W'(SLAB_BLOCKS));
    assign w_live_dn   = scfla_pkg::count_down(w_cur_live);
    assign w_idle_dn   = scfla_pkg::count_down(w_cur_idle);

    assign w_first     = HW'(32'(w_cur_slabs) * 32'(SLAB_BLOCKS));
    assign w_free_idx  = HW'(r_handle);
    assign w_free_ok   = (32'(r_handle) < 32'(HANDLES));
    assign w_free_push = (r_mode == scfla_pkg::MODE_FREE) && r_present && !r_large
                         && w_free_ok;
    assign w_alloc_go  = (r_mode == scfla_pkg::MODE_ALLOC) && !r_large;
    assign w_sel_ok    = (32'(r_sel) < 32'(CLASS_COUNT));
    assign w_sel_idx   = CW'(r_sel);
    assign w_clear     = i_cmd.finish && (r_mode == scfla_pkg::MODE_CLEAR);

    always_comb begin
        o_stat.alloc_hit    = w_alloc_go && w_cur_vld;
        o_stat.alloc_refill = w_alloc_go && !w_cur_vld
                              && (32'(w_cur_slabs) < 32'(MAX_SLABS));
        o_stat.fill_last    = (r_fill_cnt == FW'(SLAB_BLOCKS - 1));
        o_stat.rsp_open     = !r_out_valid || i_out_ready;
    end

    // link memory write port: push on free, chain on slab fill
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_cls, w_free_idx};
        w_wdata = {w_cur_vld, w_cur_head};
        if (i_cmd.fill_wr) begin
            w_we    = 1'b1;
            w_waddr = {r_cls, r_fill_addr};
            w_wdata = {!o_stat.fill_last, r_fill_addr + HW'(1)};
        end else if (i_cmd.finish && w_free_push) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_cmd.rd_head) begin
            r_rdata <= r_mem[{r_cls, w_cur_head}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_init) begin
            r_fill_addr <= w_first;
            r_fill_cnt  <= '0;
        end else if (i_cmd.fill_wr) begin
            r_fill_addr <= r_fill_addr + HW'(1);
            r_fill_cnt  <= r_fill_cnt + FW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            for (int c = 0; c < CLASS_COUNT; c++) begin
                r_head_vld[c] <= 1'b0;
                r_slabs[c]    <= '0;
                r_live[c]     <= '0;
                r_idle[c]     <= '0;
            end
        end else begin
            if (i_cmd.finish && w_free_push) begin
                r_head[r_cls]     <= w_free_idx;
                r_head_vld[r_cls] <= 1'b1;
                r_idle[r_cls]     <= w_idle_up;
                r_live[r_cls]     <= w_live_dn;
            end
            if (i_cmd.fill_init) begin
                r_head[r_cls]     <= w_first;
                r_head_vld[r_cls] <= 1'b1;
                r_slabs[r_cls]    <= w_cur_slabs + SW'(1);
                r_idle[r_cls]     <= w_idle_slab;
            end
            if (i_cmd.pop) begin
                r_head[r_cls]     <= r_rdata[HW-1:0];
                r_head_vld[r_cls] <= r_rdata[HW];
                r_idle[r_cls]     <= w_idle_dn;
                r_live[r_cls]     <= w_live_up;
            end
        end
    end

    // result of every item that completes without a pop
    always_comb begin
        w_res_status = scfla_pkg::ST_OK;
        w_res_cls    = '0;
        w_res_alloc  = '0;
        w_res_free   = '0;
        unique case (r_mode)
            scfla_pkg::MODE_ALLOC: begin
                if (r_large) begin
                    w_res_status = scfla_pkg::ST_TOO_LARGE;
                end else begin
                    w_res_status = scfla_pkg::ST_NO_SLABS;
                    w_res_cls    = r_cls;
                    w_res_alloc  = w_cur_live;
                    w_res_free   = w_cur_idle;
                end
            end
            scfla_pkg::MODE_FREE: begin
                priority if (!r_present) begin
                    w_res_status = scfla_pkg::ST_IGNORED;
                end else if (r_large) begin
                    w_res_status = scfla_pkg::ST_TOO_LARGE;
                end else if (!w_free_ok) begin
                    w_res_status = scfla_pkg::ST_IGNORED;
                    w_res_cls    = r_cls;
                    w_res_alloc  = w_cur_live;
                    w_res_free   = w_cur_idle;
                end else begin
                    w_res_cls    = r_cls;
                    w_res_alloc  = w_live_dn;
                    w_res_free   = w_idle_up;
                end
            end
            scfla_pkg::MODE_STATS: begin
                if (w_sel_ok) begin
                    w_res_cls   = w_sel_idx;
                    w_res_alloc = r_live[w_sel_idx];
                    w_res_free  = r_idle[w_sel_idx];
                end
            end
            scfla_pkg::MODE_CLEAR: begin
                w_res_status = scfla_pkg::ST_OK;
            end
            default: begin
                w_res_status = scfla_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish || i_cmd.pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) begin
            r_out_status <= scfla_pkg::ST_OK;
            r_out_handle <= scfla_pkg::HANDLE_OUT_W'(w_cur_head);
            r_out_class  <= 2'(r_cls);
            r_out_alloc  <= w_live_up;
            r_out_spare  <= w_idle_dn;
        end else if (i_cmd.finish) begin
            r_out_status <= w_res_status;
            r_out_handle <= '0;
            r_out_class  <= 2'(w_res_cls);
            r_out_alloc  <= w_res_alloc;
            r_out_spare  <= w_res_free;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_granted_handle  = r_out_handle;
    assign o_size_class      = r_out_class;
    assign o_allocated_count = r_out_alloc;
    assign o_spare_count     = r_out_spare;

endmodule

// ===== design/size_class_free_list_allocator_core.sv =====
// Size-class free-list allocator: four LIFO block pools sharing one link memory.
// Requests enter on i_req (alloc, free, stats query, clear); one response item
// leaves on o_rsp for every request, in order.
// An item is taken only when the block is idle; one item is in work at a time.
// Steps from accept edge to response valid:
//   free, stats, clear, and alloc that fails: the execute state loads the response.
//   alloc from a non-empty list: execute, then pop, which waits on the registered
//   read of the link memory.
//   alloc that claims a new slab: execute, slab fill, link read and pop, with
//   one link write per block of the slab through the single write port.
// The response sits in an output register; while it waits, a new item is
// accepted and runs up to the point where it must load its own response.
// Reset (synchronous, active low) empties every class and zeroes all counts;
// the link memory needs no clearing pass.
// Clear empties every class and zeroes all counts, as reset does.
// Depends on scfla_pkg, scfla_if, scfla_ctrl, scfla_dp and the assertion header.
`include "size_class_free_list_allocator_core_assert.svh"

module size_class_free_list_allocator_core #(
    parameter int SLAB_BLOCKS     = scfla_pkg::SLAB_BLOCKS,
    parameter int MAX_SLABS       = scfla_pkg::MAX_SLABS,
    parameter int CLASS_COUNT     = scfla_pkg::CLASS_COUNT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scfla_req_if.sink     i_req,
    scfla_rsp_if.source   o_rsp
);

    scfla_pkg::t_cmd  w_cmd;
    scfla_pkg::t_stat w_stat;
    logic             w_req_acc;
    logic             w_done;
    logic             w_link_busy;

    scfla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_req_ready (i_req.ready)
    );

    scfla_dp #(
        .SLAB_BLOCKS     (SLAB_BLOCKS),
        .MAX_SLABS       (MAX_SLABS),
        .CLASS_COUNT     (CLASS_COUNT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_mode            (i_req.mode),
        .i_request_size    (i_req.request_size),
        .i_block_handle    (i_req.block_handle),
        .i_handle_present  (i_req.handle_present),
        .i_class_select    (i_req.class_select),
        .i_out_ready       (o_rsp.ready),
        .o_out_valid       (o_rsp.valid),
        .o_status          (o_rsp.status),
        .o_granted_handle  (o_rsp.granted_handle),
        .o_size_class      (o_rsp.size_class),
        .o_allocated_count (o_rsp.allocated_count),
        .o_spare_count     (o_rsp.spare_count)
    );

    assign w_req_acc   = i_req.valid && i_req.ready;
    assign w_done      = w_cmd.pop || w_cmd.finish;
    assign w_link_busy = w_cmd.rd_head || w_cmd.finish;

    `SCFLA_ASSERT(a_one_item, i_clk, i_rst_n, w_req_acc |=> !i_req.ready, "busy accept")
    `SCFLA_ASSERT(a_pop_emits, i_clk, i_rst_n, w_cmd.pop |=> o_rsp.valid, "pop without item")
    `SCFLA_ASSERT(a_rsp_src, i_clk, i_rst_n, $rose(o_rsp.valid) |-> $past(w_done), "stray item")
    `SCFLA_NEVER(a_port_clash, i_clk, i_rst_n, w_cmd.fill_wr && w_link_busy, "port clash")

endmodule
